### rtl/core/mcem_pkg.sv
package mcem_pkg;

    localparam int CHANNELS   = 8;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths of the stream words.
    localparam int CH_W       = 3;
    localparam int V_W        = 16;
    localparam int I_W        = 16;
    localparam int P_W        = 21;
    localparam int MAG_W      = P_W - 1;
    localparam int T_W        = 32;
    localparam int PF_W       = 17;
    localparam int E_W        = 56;
    localparam int PH_W       = 8;
    localparam int THR_W      = 32;

    localparam int APP_W      = V_W + I_W;
    localparam int MILLI_W    = 10;
    localparam int M1K_W      = MAG_W + MILLI_W;
    localparam int ADD_W      = T_W + MAG_W;

    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int S_FIELDS_W = CH_W + V_W + I_W + P_W + T_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = CH_W + PF_W + E_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_APP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_EVERY = 2'd1;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 32'd1000;
    localparam logic [PH_W-1:0]    PUBLISH_RESET   = 8'd5;
    localparam logic [MILLI_W-1:0] MILLI           = 10'd1000;
    localparam logic [PF_W-1:0]    PF_ONE          = 17'h10000;
    localparam logic [E_W-1:0]     ENERGY_MAX      = {E_W{1'b1}};

    typedef struct packed {
        logic load_in;
        logic mul;
        logic update;
        logic div_step;
        logic load_out;
    } mcem_cmd_t;

    typedef struct packed {
        logic div_done;
    } mcem_stat_t;

endpackage

### rtl/core/multichannel_energy_meter_step.sv
// Channel   | Ports                                  | Word
// ----------+----------------------------------------+--------------------------------
// input     | s_tvalid, s_tready, s_tdata[87:0]      | one measurement
// result    | m_tvalid, m_tready, m_tdata[79:0]      | power factor, energy, publish
// config    | cfg_wr_en, cfg_index[1:0], cfg_wdata   | 0: apparent_threshold, 1: publish_every
//
// A word passes through capture, multiply, state update, 16 steps of the restoring power
// factor divider and output load; the next word is accepted only after that output load.
// A finished result waits in the output register while the next word is accepted;
// that word's output load then stalls until the register has been taken.
// Reset (synchronous, active low) clears all channel state and loads the register defaults.
module multichannel_energy_meter_step (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // channel[2:0], voltage_cv[18:3], current_ma[34:19], power_cw[55:35], now_ms[87:56]
    input  logic [mcem_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_channel[2:0], power_factor_q16[19:3], energy_cw_ms[75:20], publish[76], zeros above
    output logic [mcem_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [mcem_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcem_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    mcem_pkg::mcem_cmd_t  cmd;
    mcem_pkg::mcem_stat_t stat;

    mcem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mcem_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

### rtl/core/mcem_ctrl.sv
module mcem_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output mcem_pkg::mcem_cmd_t   cmd,
    input  mcem_pkg::mcem_stat_t  stat
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // The previous word may still sit in the output register.
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_MUL)
        else $error("accepted word did not start the multiply step");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && stat.div_done |=> state_reg == ST_OUT)
        else $error("divider finished but no output step followed");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !m_tvalid_reg || m_tready)
        else $error("output register overwritten while a word was pending");

endmodule

### rtl/core/mcem_dpath.sv
module mcem_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mcem_pkg::mcem_cmd_t                   cmd,
    output mcem_pkg::mcem_stat_t                  stat,
    input  logic [mcem_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic [mcem_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [mcem_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mcem_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int CH  = mcem_pkg::CHANNELS;
    localparam int IXW = mcem_pkg::CH_IDX_W;

    // Configuration and per-channel state.
    logic [mcem_pkg::THR_W-1:0] thr_reg;
    logic [mcem_pkg::PH_W-1:0]  pub_every_reg;
    logic [mcem_pkg::E_W-1:0]   energy_reg    [CH];
    logic [mcem_pkg::T_W-1:0]   last_time_reg [CH];
    logic [mcem_pkg::PH_W-1:0]  phase_reg     [CH];

    // Captured sample.
    logic [mcem_pkg::CH_W-1:0]  ch_reg;
    logic [mcem_pkg::V_W-1:0]   v_reg;
    logic [mcem_pkg::I_W-1:0]   i_reg;
    logic [mcem_pkg::P_W-1:0]   p_reg;
    logic [mcem_pkg::T_W-1:0]   now_reg;
    logic [mcem_pkg::T_W-1:0]   dt_reg;
    logic                       first_reg;

    // Products.
    logic [mcem_pkg::APP_W-1:0] app_reg;
    logic [mcem_pkg::M1K_W-1:0] m1k_reg;
    logic [mcem_pkg::ADD_W-1:0] add_reg;

    // Divider and results.
    logic [mcem_pkg::APP_W-1:0]     rem_reg;
    logic [mcem_pkg::DIV_STEPS-1:0] quo_reg;
    logic [mcem_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           pf_zero_reg;
    logic                           pf_sat_reg;
    logic [mcem_pkg::E_W-1:0]       e_res_reg;
    logic                           pub_res_reg;

    logic [mcem_pkg::CH_W-1:0]  m_ch_reg;
    logic [mcem_pkg::PF_W-1:0]  m_pf_reg;
    logic [mcem_pkg::E_W-1:0]   m_energy_reg;
    logic                       m_pub_reg;

    // Input unpacking.
    logic [mcem_pkg::CH_W-1:0]  s_ch;
    logic [mcem_pkg::V_W-1:0]   s_v;
    logic [mcem_pkg::I_W-1:0]   s_i;
    logic [mcem_pkg::P_W-1:0]   s_p;
    logic [mcem_pkg::T_W-1:0]   s_now;
    logic [IXW-1:0]             s_idx;

    assign {s_now, s_p, s_i, s_v, s_ch} = s_tdata[mcem_pkg::S_FIELDS_W-1:0];
    assign s_idx = IXW'(s_ch);

    logic [mcem_pkg::MAG_W-1:0] mag;
    logic                       neg;
    logic [IXW-1:0]             idx;
    logic                       ch_ok;

    assign mag   = p_reg[mcem_pkg::MAG_W-1:0];
    assign neg   = p_reg[mcem_pkg::P_W-1];
    assign idx   = IXW'(ch_reg);
    assign ch_ok = int'(ch_reg) < CH;

    // Energy and publish update.
    logic [mcem_pkg::E_W:0]     e_sum;
    logic [mcem_pkg::E_W-1:0]   e_next;
    logic [mcem_pkg::PH_W:0]    ph_inc;
    logic [mcem_pkg::PH_W:0]    ph_mod;
    logic                       pub_next;
    logic [mcem_pkg::PH_W-1:0]  ph_next;

    always_comb begin
        e_sum  = {1'b0, energy_reg[idx]} + (mcem_pkg::E_W + 1)'(add_reg);
        e_next = energy_reg[idx];
        if (!first_reg && dt_reg != '0 && !neg && mag != '0) begin
            e_next = e_sum[mcem_pkg::E_W] ? mcem_pkg::ENERGY_MAX : e_sum[mcem_pkg::E_W-1:0];
        end
        ph_inc   = {1'b0, phase_reg[idx]} + 1'b1;
        ph_mod   = (pub_every_reg == '0) ? (mcem_pkg::PH_W + 1)'(1)
                                         : {1'b0, pub_every_reg};
        pub_next = ph_inc >= ph_mod;
        ph_next  = pub_next ? '0 : ph_inc[mcem_pkg::PH_W-1:0];
    end

    // One restoring step: shift, compare, subtract.
    logic [mcem_pkg::APP_W:0]   rem_sh;
    logic                       rem_ge;
    logic [mcem_pkg::APP_W:0]   rem_diff;

    always_comb begin
        rem_sh   = {rem_reg, 1'b0};
        rem_ge   = rem_sh >= {1'b0, app_reg};
        rem_diff = rem_sh - {1'b0, app_reg};
    end

    logic [mcem_pkg::PF_W-1:0] pf_final;

    always_comb begin
        if (pf_zero_reg) begin
            pf_final = '0;
        end else if (pf_sat_reg) begin
            pf_final = mcem_pkg::PF_ONE;
        end else begin
            pf_final = mcem_pkg::PF_W'(quo_reg);
        end
    end

    assign stat.div_done = (cnt_reg == mcem_pkg::DIV_CNT_W'(mcem_pkg::DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= mcem_pkg::THRESHOLD_RESET;
            pub_every_reg <= mcem_pkg::PUBLISH_RESET;
            for (int k = 0; k < CH; k++) begin
                energy_reg[k]    <= '0;
                last_time_reg[k] <= '0;
                phase_reg[k]     <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mcem_pkg::REG_APP_THRESHOLD: thr_reg <= cfg_wdata;
                    mcem_pkg::REG_PUBLISH_EVERY: pub_every_reg <= cfg_wdata[mcem_pkg::PH_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.update && ch_ok) begin
                energy_reg[idx]    <= e_next;
                last_time_reg[idx] <= now_reg;
                phase_reg[idx]     <= ph_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ch_reg    <= s_ch;
            v_reg     <= s_v;
            i_reg     <= s_i;
            p_reg     <= s_p;
            now_reg   <= s_now;
            dt_reg    <= s_now - last_time_reg[s_idx];
            first_reg <= (last_time_reg[s_idx] == '0);
        end
        if (cmd.mul) begin
            app_reg <= v_reg * i_reg;
            m1k_reg <= mag * mcem_pkg::MILLI;
            add_reg <= dt_reg * mag;
        end
        if (cmd.update) begin
            pf_zero_reg <= (app_reg <= thr_reg) || neg || (mag == '0);
            // A quotient of one or more clamps, so only the fraction is divided.
            pf_sat_reg  <= mcem_pkg::APP_W'(m1k_reg) >= app_reg;
            rem_reg     <= mcem_pkg::APP_W'(m1k_reg);
            quo_reg     <= '0;
            cnt_reg     <= '0;
            e_res_reg   <= ch_ok ? e_next : '0;
            pub_res_reg <= ch_ok && pub_next;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_diff[mcem_pkg::APP_W-1:0] : rem_sh[mcem_pkg::APP_W-1:0];
            quo_reg <= {quo_reg[mcem_pkg::DIV_STEPS-2:0], rem_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.load_out) begin
            m_ch_reg     <= ch_reg;
            m_pf_reg     <= pf_final;
            m_energy_reg <= e_res_reg;
            m_pub_reg    <= pub_res_reg;
        end
    end

    assign m_tdata = mcem_pkg::M_TDATA_W'({m_pub_reg, m_energy_reg, m_pf_reg, m_ch_reg});

    a_pf_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_pf_reg <= mcem_pkg::PF_ONE)
        else $error("power factor above one reached the output");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step && !pf_sat_reg |-> rem_reg < app_reg)
        else $error("divider remainder not below the divisor");

endmodule

### dv/multichannel_energy_meter_step_tb.sv
`timescale 1ns / 100ps

module multichannel_energy_meter_step_tb;

    import mcem_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_WORDS   = 190;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 400;

    // Packed MSB first, so the channel lands in the lowest bits of s_tdata.
    typedef struct packed {
        logic [T_W-1:0]  now_ms;
        logic [P_W-1:0]  power_cw;
        logic [I_W-1:0]  current_ma;
        logic [V_W-1:0]  voltage_cv;
        logic [CH_W-1:0] channel;
    } meas_t;

    typedef struct packed {
        logic            publish;
        logic [E_W-1:0]  energy_cw_ms;
        logic [PF_W-1:0] power_factor_q16;
        logic [CH_W-1:0] out_channel;
    } reading_t;

    class meter_scoreboard;
        logic [E_W-1:0]   acc_energy  [CHANNELS];
        logic [T_W-1:0]   prev_stamp  [CHANNELS];
        logic [PH_W-1:0]  cadence_cnt [CHANNELS];
        logic [THR_W-1:0] min_apparent;
        logic [PH_W-1:0]  cadence;
        reading_t         expected_readings[$];
        int unsigned      mismatches;

        function new();
            for (int c = 0; c < CHANNELS; c++) begin
                acc_energy[c]  = '0;
                prev_stamp[c]  = '0;
                cadence_cnt[c] = '0;
            end
            min_apparent = THRESHOLD_RESET;
            cadence      = PUBLISH_RESET;
            mismatches   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_APP_THRESHOLD: min_apparent = val[THR_W-1:0];
                REG_PUBLISH_EVERY: cadence = val[PH_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_measurement(meas_t m);
            reading_t    r;
            logic [63:0] apparent;
            logic [63:0] ratio;
            logic [63:0] gain;
            logic [63:0] room;
            logic [31:0] step;
            logic [8:0]  phase;
            logic [8:0]  period;
            logic        negative;
            negative = m.power_cw[P_W-1];
            apparent = {48'd0, m.voltage_cv} * {48'd0, m.current_ma};
            r.out_channel = m.channel;
            if (apparent <= {32'd0, min_apparent} || apparent == 0 || negative ||
                m.power_cw == 0) begin
                r.power_factor_q16 = '0;
            end else begin
                ratio = ({43'd0, m.power_cw} * 64'd65536000) / apparent;
                r.power_factor_q16 = (ratio > 64'd65536) ? PF_ONE : ratio[PF_W-1:0];
            end
            // A stored time of zero means the channel has not started yet.
            if (prev_stamp[m.channel] != 0) begin
                step = m.now_ms - prev_stamp[m.channel];
                if (step != 0 && !negative && m.power_cw != 0) begin
                    gain = {32'd0, step} * {43'd0, m.power_cw};
                    room = {8'd0, ENERGY_MAX} - {8'd0, acc_energy[m.channel]};
                    if (gain > room)
                        acc_energy[m.channel] = ENERGY_MAX;
                    else
                        acc_energy[m.channel] = acc_energy[m.channel] + gain[E_W-1:0];
                end
            end
            prev_stamp[m.channel] = m.now_ms;
            r.energy_cw_ms = acc_energy[m.channel];
            period = (cadence == 0) ? 9'd1 : {1'b0, cadence};
            phase  = {1'b0, cadence_cnt[m.channel]} + 9'd1;
            r.publish = 1'b0;
            if (phase >= period) begin
                phase     = '0;
                r.publish = 1'b1;
            end
            cadence_cnt[m.channel] = phase[PH_W-1:0];
            expected_readings.push_back(r);
        endfunction

        function void check_reading(logic [M_TDATA_W-1:0] word);
            reading_t got;
            reading_t want;
            got = word[M_FIELDS_W-1:0];
            if (expected_readings.size() == 0) begin
                $error("result word on channel %0d with nothing pending", got.out_channel);
                mismatches++;
                return;
            end
            want = expected_readings.pop_front();
            if (got.out_channel != want.out_channel) begin
                $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
                mismatches++;
            end
            if (got.power_factor_q16 != want.power_factor_q16) begin
                $error("power_factor_q16: expected %0d, got %0d",
                       want.power_factor_q16, got.power_factor_q16);
                mismatches++;
            end
            if (got.energy_cw_ms != want.energy_cw_ms) begin
                $error("energy_cw_ms: expected %0d, got %0d",
                       want.energy_cw_ms, got.energy_cw_ms);
                mismatches++;
            end
            if (got.publish != want.publish) begin
                $error("publish: expected %0d, got %0d", want.publish, got.publish);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    meter_scoreboard sb;
    bit              no_idle;
    bit              hold_output;
    int unsigned     cycles;
    logic [T_W-1:0]  stamp_sent [CHANNELS];

    multichannel_energy_meter_step uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic meas_t make_meas(logic [CH_W-1:0] ch, logic [V_W-1:0] v,
                                        logic [I_W-1:0] i, logic [P_W-1:0] p,
                                        logic [T_W-1:0] t);
        meas_t m;
        m.channel    = ch;
        m.voltage_cv = v;
        m.current_ma = i;
        m.power_cw   = p;
        m.now_ms     = t;
        return m;
    endfunction

    function automatic meas_t next_measurement();
        meas_t       m;
        int unsigned pick;
        m.channel = CH_W'($urandom_range(0, CHANNELS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            // Apparent power around the default threshold.
            m.voltage_cv = V_W'($urandom_range(0, 60));
            m.current_ma = I_W'($urandom_range(0, 60));
            m.power_cw   = P_W'($urandom_range(0, 8));
        end else if (pick < 60) begin
            // Power factor mostly above one.
            m.voltage_cv = V_W'($urandom_range(0, 2000));
            m.current_ma = I_W'($urandom_range(0, 2000));
            m.power_cw   = P_W'($urandom_range(0, 4000));
        end else begin
            m.voltage_cv = V_W'($urandom_range(0, 65535));
            m.current_ma = I_W'($urandom_range(0, 65535));
            m.power_cw   = P_W'($urandom_range(0, 21'h0FFFFF));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            m.power_cw = '0;
        else if (pick < 3)
            m.power_cw = 21'h100000 | P_W'($urandom_range(0, 21'h0FFFFF));
        else if (pick == 3)
            m.power_cw = 21'h0FFFFF;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            m.now_ms = '0;
        else if (pick == 1)
            m.now_ms = stamp_sent[m.channel];
        else if (pick == 2)
            m.now_ms = $urandom;
        else
            m.now_ms = stamp_sent[m.channel] + $urandom_range(1, 5000);
        stamp_sent[m.channel] = m.now_ms;
        return m;
    endfunction

    task automatic send_measurement(input meas_t m);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        do @(posedge aclk); while (!s_tready);
        sb.accept_measurement(m);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [THR_W-1:0] thr, input logic [PH_W-1:0] every);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_APP_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge aclk);
        sb.set_register(REG_APP_THRESHOLD, thr);
        cfg_index <= REG_PUBLISH_EVERY;
        cfg_wdata <= {{(CFG_DATA_W - PH_W){1'b0}}, every};
        @(posedge aclk);
        sb.set_register(REG_PUBLISH_EVERY, {{(CFG_DATA_W - PH_W){1'b0}}, every});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [THR_W-1:0] thr, input logic [PH_W-1:0] every,
                             input bit quiet, input bit hold);
        drain();
        write_settings(thr, every);
        no_idle     = quiet;
        hold_output = hold;
        repeat (PHASE_WORDS) send_measurement(next_measurement());
    endtask

    // Result side: random stalls, with one long hold-off so the block backs up.
    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (hold_output) begin
                stall       = LONG_HOLD;
                hold_output = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_reading(m_tdata);
        end
    end

    initial begin
        int unsigned k;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_APP_THRESHOLD;
        cfg_wdata   <= '0;
        aresetn     <= 1'b0;
        no_idle     = 1'b0;
        hold_output = 1'b0;
        for (k = 0; k < CHANNELS; k++)
            stamp_sent[k] = '0;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset settings.
        send_measurement(make_meas(0, 0, 0, 0, 0));                   // time zero: not started
        send_measurement(make_meas(0, 23000, 5000, 100000, 1000));    // first sample
        send_measurement(make_meas(0, 23000, 5000, 100000, 1500));
        send_measurement(make_meas(0, 23000, 5000, 100000, 1500));    // zero time step
        send_measurement(make_meas(0, 23000, 5000, 21'h100000, 2000)); // most negative
        send_measurement(make_meas(0, 23000, 5000, 21'h1FFFFF, 2500)); // minus one
        send_measurement(make_meas(0, 23000, 5000, 0, 3000));
        send_measurement(make_meas(0, 100, 100, 21'h0FFFFF, 4000));   // factor above one
        send_measurement(make_meas(1, 10, 100, 1, 32'hFFFF_FFFF));    // apparent at threshold
        send_measurement(make_meas(1, 7, 143, 1, 5));                 // just above, time wraps
        send_measurement(make_meas(2, 16'hFFFF, 16'hFFFF, 21'h0FFFFF, 32'h8000_0000));
        send_measurement(make_meas(3, 16'h5555, 16'hAAAA, 21'h0AAAAA, 32'h5555_5555));
        send_measurement(make_meas(4, 16'hAAAA, 16'h5555, 21'h155555, 32'hAAAA_AAAA));
        send_measurement(make_meas(3, 16'h5555, 16'hAAAA, 21'h0AAAAA, 32'h5555_5556));
        // Largest steps at full power drive channel 7 into saturation.
        for (k = 0; k < 18; k++)
            send_measurement(make_meas(7, 23000, 4000, 21'h0FFFFF, 32'h1000_0000 - k));

        run_phase(32'd0, 8'd1, 1'b1, 1'b0);
        run_phase(32'hFFFF_FFFF, 8'd255, 1'b0, 1'b1);
        run_phase(32'd1000, 8'd3, 1'b0, 1'b0);
        run_phase($urandom, 8'd0, 1'b0, 1'b0);
        run_phase($urandom_range(0, 5000), PH_W'($urandom_range(1, 255)), 1'b0, 1'b0);

        drain();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
